// ----- hdl/rgt_pkg.sv -----
// Shared types and constants for the run and gap tokenizer.
package rgt_pkg;

    localparam int SYM_W     = 8;
    localparam int SYM_COUNT = 256;
    localparam int SYM_AW    = $clog2(SYM_COUNT);
    localparam int FIELD_W   = 40;

    typedef logic [SYM_W-1:0]   t_sym;
    typedef logic [FIELD_W-1:0] t_field;

    // request codes on the input channel
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOS  = 1'b1;

endpackage

// ----- hdl/rgt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rgt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/run_gap_tokenizer.sv -----
// Run and gap tokenizer: splits a byte stream into runs and emits gap tokens.
// After its closing transaction is accepted, a token passes through stage 1 (cursor
//   RAM read) and then the output register before it is on the outputs.
// Throughput: one input transaction per cycle; the input stalls only while stage 1 and
//   the output register both hold tokens and the output side is stalled.
// Reset (synchronous, active low) clears the run state, the position counter, the
//   overflow flag and the 256 cursor valid bits; invalid cursors read as zero.
module run_gap_tokenizer #(
    parameter int POS_BITS = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [7:0]            i_byte_value,
    // token channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_symbol,
    output logic [39:0]           o_gap,
    output logic [39:0]           o_run_len_minus_one,
    output logic                  o_final_token,
    output logic                  o_overflow
);

    typedef logic [POS_BITS-1:0] t_pos;

    // closed-run record between the accept stage and the cursor update stage
    typedef struct packed {
        logic          fin;     // closed by end of stream
        logic          ovf;     // overflow flag as it stood at the close
        logic          fwd;     // use ovr instead of the RAM data
        rgt_pkg::t_sym sym;
        t_pos          start;
        t_pos          len;
        t_pos          ovr;     // forwarded cursor or zero for a never-written entry
    } t_close;

    localparam t_pos POS_MAX = {POS_BITS{1'b1}};

    // run state
    logic          r_run_open, n_run_open;
    rgt_pkg::t_sym r_cur_sym,  n_cur_sym;
    t_pos          r_start_pos, n_start_pos;
    t_pos          r_run_len,  n_run_len;
    t_pos          r_pos,      n_pos;
    logic          r_ovf_seen, n_ovf_seen;

    // cursor valid bits, one per symbol
    logic [rgt_pkg::SYM_COUNT-1:0] r_cur_vld;

    // stage 1: waiting on the cursor read
    logic   r_s1v, n_s1v;
    t_close r_s1,  n_s1;

    // output register
    logic             r_ov, n_ov;
    rgt_pkg::t_sym    r_o_sym;
    rgt_pkg::t_field  r_o_gap;
    rgt_pkg::t_field  r_o_rlm1;
    logic             r_o_fin;
    logic             r_o_ovf;

    logic   out_free, s1_adv, s1_free, acc, is_eos, close;
    t_pos   ram_rdata, cur, gap, rlm1, s1_end;
    logic [POS_BITS:0] end_sum;

    // ---------------------------------------------------------------
    // Handshake. Stage 1 drains into the output register whenever the
    // output register is empty or its token is being taken.
    // ---------------------------------------------------------------
    assign out_free   = !r_ov || !i_out_stall;
    assign s1_adv     = r_s1v && out_free;
    assign s1_free    = !r_s1v || out_free;
    assign o_in_stall = !s1_free;
    assign acc        = i_in_valid && s1_free;
    assign is_eos     = (i_req_type == rgt_pkg::REQ_EOS);

    // a run closes on end of stream or on a different byte
    assign close = acc && r_run_open && (is_eos || (i_byte_value != r_cur_sym));

    // ---------------------------------------------------------------
    // Stage 1 arithmetic: gap, run length minus one, new cursor.
    // ---------------------------------------------------------------
    assign cur     = r_s1.fwd ? r_s1.ovr : ram_rdata;
    assign gap     = (r_s1.start >= cur) ? (r_s1.start - cur) : '0;
    assign rlm1    = (r_s1.len != '0) ? (r_s1.len - t_pos'(1)) : '0;
    assign end_sum = {1'b0, r_s1.start} + {1'b0, r_s1.len};
    assign s1_end  = end_sum[POS_BITS] ? POS_MAX : end_sum[POS_BITS-1:0];

    rgt_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (rgt_pkg::SYM_COUNT)
    ) u_cursor_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1.sym),
        .i_wdata (s1_end),
        .i_re    (close),
        .i_raddr (r_cur_sym),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Accept stage: run tracking, position counter, close record.
    // ---------------------------------------------------------------
    always_comb begin
        n_run_open  = r_run_open;
        n_cur_sym   = r_cur_sym;
        n_start_pos = r_start_pos;
        n_run_len   = r_run_len;
        n_pos       = r_pos;
        n_ovf_seen  = r_ovf_seen;

        if (acc) begin
            if (is_eos) begin
                n_run_open = 1'b0;
            end else begin
                if (r_run_open && (i_byte_value == r_cur_sym)) begin
                    if (r_run_len == POS_MAX) begin
                        n_ovf_seen = 1'b1;
                    end else begin
                        n_run_len = r_run_len + t_pos'(1);
                    end
                end else begin
                    n_run_open  = 1'b1;
                    n_cur_sym   = i_byte_value;
                    n_start_pos = r_pos;
                    n_run_len   = t_pos'(1);
                end
                if (r_pos == POS_MAX) begin
                    n_ovf_seen = 1'b1;
                end else begin
                    n_pos = r_pos + t_pos'(1);
                end
            end
        end

        // close record; the RAM read of r_cur_sym is issued this cycle.
        // A write to the same entry at this edge would be missed by the read,
        // so its data is forwarded; a never-written entry reads as zero.
        n_s1v = close ? 1'b1 : (s1_adv ? 1'b0 : r_s1v);
        n_s1  = r_s1;
        if (close) begin
            n_s1.fin   = is_eos;
            n_s1.ovf   = r_ovf_seen;
            n_s1.sym   = r_cur_sym;
            n_s1.start = r_start_pos;
            n_s1.len   = r_run_len;
            if (s1_adv && (r_s1.sym == r_cur_sym)) begin
                n_s1.fwd = 1'b1;
                n_s1.ovr = s1_end;
            end else if (!r_cur_vld[r_cur_sym]) begin
                n_s1.fwd = 1'b1;
                n_s1.ovr = '0;
            end else begin
                n_s1.fwd = 1'b0;
                n_s1.ovr = '0;
            end
        end

        n_ov = s1_adv ? 1'b1 : ((r_ov && !i_out_stall) ? 1'b0 : r_ov);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_cur_sym   <= '0;
            r_start_pos <= '0;
            r_run_len   <= '0;
            r_pos       <= '0;
            r_ovf_seen  <= 1'b0;
            r_cur_vld   <= '0;
            r_s1v       <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_run_open  <= n_run_open;
            r_cur_sym   <= n_cur_sym;
            r_start_pos <= n_start_pos;
            r_run_len   <= n_run_len;
            r_pos       <= n_pos;
            r_ovf_seen  <= n_ovf_seen;
            r_s1v       <= n_s1v;
            r_ov        <= n_ov;
            if (s1_adv) begin
                r_cur_vld[r_s1.sym] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        if (s1_adv) begin
            r_o_sym  <= r_s1.sym;
            r_o_gap  <= rgt_pkg::FIELD_W'(gap);
            r_o_rlm1 <= rgt_pkg::FIELD_W'(rlm1);
            r_o_fin  <= r_s1.fin;
            r_o_ovf  <= r_s1.ovf;
        end
    end

    assign o_out_valid         = r_ov;
    assign o_symbol            = r_o_sym;
    assign o_gap               = r_o_gap;
    assign o_run_len_minus_one = r_o_rlm1;
    assign o_final_token       = r_o_fin;
    assign o_overflow          = r_o_ovf;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1v && r_ov))
        else $error("input stalled without a pending token");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf_seen |=> r_ovf_seen)
        else $error("overflow flag cleared within a stream");

    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_open |-> ((r_pos >= r_start_pos) && (r_run_len != '0)))
        else $error("open run inconsistent with position");

    a_close_loads_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close |=> r_s1v)
        else $error("closed run lost before cursor stage");

    a_s1_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !close) |=> (!r_s1v && r_ov))
        else $error("stage 1 did not hand its token to the output");

endmodule
